// ----- rtl/oale_pkg.sv -----
// Shared types and codes for the ordered array list engine.
`timescale 1ns / 1ps

package oale_pkg;

    typedef enum logic [2:0] {
        K_INSERT_AT     = 3'd0,
        K_INSERT_SORTED = 3'd1,
        K_ERASE         = 3'd2,
        K_REMOVE_ALL    = 3'd3,
        K_GET           = 3'd4,
        K_SET           = 3'd5,
        K_FIND          = 3'd6
    } kind_t;

    localparam int KIND_W = 3;

    typedef struct packed {
        logic shift;
        logic compact;
        logic parity;
    } cell_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } proc_ctl_t;

    typedef struct packed {
        logic go;
        logic compact;
    } proc_stat_t;

endpackage

// ----- rtl/oale_cell.sv -----
// One list cell: holds an item and an occupied mark, rotates or compacts with its neighbors.
`timescale 1ns / 1ps

module oale_cell #(
    parameter int ITEM_WIDTH = 32
) (
    input  logic                  clk,
    input  oale_pkg::cell_ctl_t   ctl,
    input  logic                  odd,
    input  logic                  left_vld,
    input  logic [ITEM_WIDTH-1:0] right_item,
    input  logic                  right_vld,
    output logic [ITEM_WIDTH-1:0] item,
    output logic                  vld
);
    import oale_pkg::*;

    logic [ITEM_WIDTH-1:0] item_reg;
    logic [ITEM_WIDTH-1:0] item_next;
    logic                  vld_reg;
    logic                  vld_next;

    // odd-even transposition: a hole swaps with an occupied right neighbor
    always_comb
    begin
        item_next = item_reg;
        vld_next  = vld_reg;
        if (ctl.shift)
        begin
            item_next = right_item;
            vld_next  = right_vld;
        end
        else if (ctl.compact)
        begin
            if (odd == ctl.parity)
            begin
                if (!vld_reg && right_vld)
                begin
                    item_next = right_item;
                    vld_next  = 1'b1;
                end
            end
            else if (!left_vld && vld_reg)
            begin
                vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        vld_reg  <= vld_next;
    end

    assign item = item_reg;
    assign vld  = vld_reg;

endmodule

// ----- rtl/oale_proc.sv -----
// Request unit: sees the list one item per cycle at the chain head and rewrites the stream.
`timescale 1ns / 1ps

module oale_proc #(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  oale_pkg::proc_ctl_t             ctl,
    output oale_pkg::proc_stat_t            stat,
    input  oale_pkg::kind_t                 kind,
    input  logic [$clog2(CAPACITY+1)-1:0]   position,
    input  logic [ITEM_WIDTH-1:0]           item_value,
    input  logic [$clog2(CAPACITY)-1:0]     slot,
    input  logic [ITEM_WIDTH-1:0]           head_item,
    output logic [ITEM_WIDTH-1:0]           emit_item,
    output logic                            emit_vld,
    output logic                            ok,
    output logic [$clog2(CAPACITY)-1:0]     result_index,
    output logic [$clog2(CAPACITY+1)-1:0]   removed_count,
    output logic [ITEM_WIDTH-1:0]           read_value,
    output logic [$clog2(CAPACITY+1)-1:0]   item_count,
    output logic                            is_empty
);
    import oale_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    kind_t                 kind_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [ITEM_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  placed_reg;
    logic [ITEM_WIDTH-1:0] buf_reg;
    logic                  buf_full_reg;
    logic                  ok_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [ITEM_WIDTH-1:0] rd_reg;

    logic             go;
    logic [CNT_W-1:0] slot_cnt;
    logic             slot_real;
    logic             slot_at_pos;
    logic             hit;
    logic             ins_op;
    logic             ins_here;
    logic [CNT_W-1:0] rem_total;

    always_comb
    begin
        case (kind)
            K_INSERT_AT:     go = (position <= count_reg) && (count_reg < CAP_CNT);
            K_INSERT_SORTED: go = count_reg < CAP_CNT;
            K_ERASE,
            K_GET,
            K_SET:           go = position < count_reg;
            K_REMOVE_ALL,
            K_FIND:          go = 1'b1;
            default:         go = 1'b0;
        endcase
    end

    always_comb
    begin
        slot_cnt    = CNT_W'(slot);
        slot_real   = slot_cnt < count_reg;
        slot_at_pos = slot_cnt == pos_reg;
        hit         = slot_real && (head_item == val_reg);
        ins_op      = (kind_reg == K_INSERT_AT) || (kind_reg == K_INSERT_SORTED);
        rem_total   = rem_reg + CNT_W'(hit);
        if (kind_reg == K_INSERT_AT)
            ins_here = ins_op && !placed_reg && slot_at_pos;
        else
            ins_here = ins_op && !placed_reg
                && ((slot_cnt == count_reg) || (slot_real && (val_reg <= head_item)));
    end

    always_comb
    begin
        emit_item = head_item;
        emit_vld  = slot_real;
        case (kind_reg)
            K_INSERT_AT,
            K_INSERT_SORTED:
            begin
                if (ins_here)
                begin
                    emit_item = val_reg;
                    emit_vld  = 1'b1;
                end
                else if (buf_full_reg)
                begin
                    emit_item = buf_reg;
                    emit_vld  = 1'b1;
                end
            end
            K_ERASE:      emit_vld  = slot_real && !slot_at_pos;
            K_REMOVE_ALL: emit_vld  = slot_real && !hit;
            K_SET:        emit_item = slot_at_pos ? val_reg : head_item;
            default:      emit_item = head_item;
        endcase
    end

    assign stat.go      = go;
    assign stat.compact = (kind_reg == K_ERASE)
        || ((kind_reg == K_REMOVE_ALL) && (rem_total != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            placed_reg   <= 1'b0;
            buf_full_reg <= 1'b0;
            ok_reg       <= 1'b0;
            kind_reg     <= K_GET;
        end
        else if (ctl.load)
        begin
            kind_reg     <= kind;
            placed_reg   <= 1'b0;
            buf_full_reg <= 1'b0;
            ok_reg       <= go && (kind != K_FIND) && (kind != K_REMOVE_ALL);
        end
        else if (ctl.step)
        begin
            if (ins_op)
            begin
                if (ins_here)
                begin
                    placed_reg   <= 1'b1;
                    buf_full_reg <= slot_real;
                end
                else if (buf_full_reg)
                begin
                    buf_full_reg <= slot_real;
                end
            end
            if ((kind_reg == K_FIND) && hit && !ok_reg)
                ok_reg <= 1'b1;
            if (slot == LAST_IDX)
            begin
                case (kind_reg)
                    K_INSERT_AT,
                    K_INSERT_SORTED: count_reg <= count_reg + 1'b1;
                    K_ERASE:         count_reg <= count_reg - 1'b1;
                    K_REMOVE_ALL:    count_reg <= count_reg - rem_total;
                    default:         count_reg <= count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pos_reg <= position;
            val_reg <= item_value;
            rem_reg <= '0;
            rd_reg  <= '0;
            idx_reg <= (go && (kind == K_INSERT_AT)) ? IDX_W'(position) : '0;
        end
        else if (ctl.step)
        begin
            if (ins_here || (ins_op && buf_full_reg))
                buf_reg <= head_item;
            if (ins_here && (kind_reg == K_INSERT_SORTED))
                idx_reg <= slot;
            if ((kind_reg == K_FIND) && hit && !ok_reg)
                idx_reg <= slot;
            if (kind_reg == K_REMOVE_ALL)
                rem_reg <= rem_total;
            if ((kind_reg == K_GET) && slot_at_pos)
                rd_reg <= head_item;
        end
    end

    assign ok            = (kind_reg == K_REMOVE_ALL) ? (rem_reg != '0) : ok_reg;
    assign result_index  = idx_reg;
    assign removed_count = rem_reg;
    assign read_value    = rd_reg;
    assign item_count    = count_reg;
    assign is_empty      = count_reg == '0;

endmodule

// ----- rtl/ordered_array_list_engine.sv -----
// Top level: cell chain, request unit, sequencing and stream ports.
// The list lives in a ring of CAPACITY cells with the request unit closing the ring. An
// accepted word that passes its checks rotates the whole ring through the unit once, the
// unit rewriting the stream as it passes (insert, sorted insert, set, get, find). Erase and
// remove_all leave holes that an odd-even compaction sweep closes after the pass; the sweep
// runs for an erase and for a remove_all that drops at least one item. A request rejected
// on range, on a full list or for an unknown kind skips the pass and goes straight to the
// result; a stalled receiver holds the result back.
// The next word is taken as soon as the result sits in the output register.
`timescale 1ns / 1ps

module ordered_array_list_engine #(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    // position, item_value
    input  logic [((($clog2(CAPACITY+1) + ITEM_WIDTH) + 7) / 8) * 8 - 1:0] s_tdata,
    // kind
    input  logic [oale_pkg::KIND_W-1:0] s_tuser,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // ok, result_index, removed_count, read_value, item_count, is_empty
    output logic [(((2 + $clog2(CAPACITY) + 2 * $clog2(CAPACITY+1) + ITEM_WIDTH) + 7) / 8)
                  * 8 - 1:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready
);
    import oale_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int OUT_W = (((2 + IDX_W + 2 * CNT_W + ITEM_WIDTH) + 7) / 8) * 8;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_PASS    = 4'b0010,
        ST_COMPACT = 4'b0100,
        ST_DONE    = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] t_reg;
    logic [IDX_W-1:0] t_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;

    logic                  accept;
    logic                  out_free;
    proc_ctl_t             pctl;
    proc_stat_t            pstat;
    cell_ctl_t             cctl;
    logic [ITEM_WIDTH-1:0] emit_item;
    logic                  emit_vld;
    logic                  r_ok;
    logic [IDX_W-1:0]      r_index;
    logic [CNT_W-1:0]      r_removed;
    logic [ITEM_WIDTH-1:0] r_read;
    logic [CNT_W-1:0]      r_count;
    logic                  r_empty;

    logic [ITEM_WIDTH-1:0] item_w [CAPACITY];
    logic                  vld_w  [CAPACITY];

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign pctl.load    = accept;
    assign pctl.step    = state_reg == ST_PASS;
    assign cctl.shift   = state_reg == ST_PASS;
    assign cctl.compact = state_reg == ST_COMPACT;
    assign cctl.parity  = t_reg[0];

    always_comb
    begin
        state_next    = state_reg;
        t_next        = t_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                t_next = '0;
                if (accept)
                    state_next = pstat.go ? ST_PASS : ST_DONE;
            end
            ST_PASS:
            begin
                t_next = t_reg + 1'b1;
                if (t_reg == LAST_IDX)
                begin
                    t_next     = '0;
                    state_next = pstat.compact ? ST_COMPACT : ST_DONE;
                end
            end
            ST_COMPACT:
            begin
                t_next = t_reg + 1'b1;
                if (t_reg == LAST_IDX)
                begin
                    t_next     = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            t_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            t_reg        <= t_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
            m_tdata_reg <= OUT_W'({r_empty, r_count, r_read, r_removed, r_index, r_ok});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    oale_proc #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_proc (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (pctl),
        .stat          (pstat),
        .kind          (kind_t'(s_tuser)),
        .position      (s_tdata[CNT_W-1:0]),
        .item_value    (s_tdata[CNT_W +: ITEM_WIDTH]),
        .slot          (t_reg),
        .head_item     (item_w[0]),
        .emit_item     (emit_item),
        .emit_vld      (emit_vld),
        .ok            (r_ok),
        .result_index  (r_index),
        .removed_count (r_removed),
        .read_value    (r_read),
        .item_count    (r_count),
        .is_empty      (r_empty)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                  left_vld;
        logic [ITEM_WIDTH-1:0] right_item;
        logic                  right_vld;

        if (i == 0)
        begin : g_head
            assign left_vld = 1'b1;
        end
        else
        begin : g_mid_l
            assign left_vld = vld_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_item = emit_item;
            assign right_vld  = emit_vld && cctl.shift;
        end
        else
        begin : g_mid_r
            assign right_item = item_w[i+1];
            assign right_vld  = vld_w[i+1];
        end

        oale_cell #(
            .ITEM_WIDTH (ITEM_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctl        (cctl),
            .odd        (1'((i % 2))),
            .left_vld   (left_vld),
            .right_item (right_item),
            .right_vld  (right_vld),
            .item       (item_w[i]),
            .vld        (vld_w[i])
        );
    end

endmodule

// ----- rtl/oale_checker.sv -----
// Port-level checks for the ordered array list engine, bound to the top level.
`timescale 1ns / 1ps

module oale_checker #(
    parameter int CAPACITY   = 256,
    parameter int ITEM_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    input logic [((($clog2(CAPACITY+1) + ITEM_WIDTH) + 7) / 8) * 8 - 1:0] s_tdata,
    input logic [oale_pkg::KIND_W-1:0] s_tuser,
    input logic s_tvalid,
    input logic s_tready,
    input logic [(((2 + $clog2(CAPACITY) + 2 * $clog2(CAPACITY+1) + ITEM_WIDTH) + 7) / 8)
                 * 8 - 1:0] m_tdata,
    input logic m_tvalid,
    input logic m_tready
);
    import oale_pkg::*;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int REM_LO  = 1 + IDX_W;
    localparam int CNT_LO  = REM_LO + CNT_W + ITEM_WIDTH;
    localparam int EMPTY_B = CNT_LO + CNT_W;

    logic [CNT_W-1:0] o_count;
    logic [CNT_W-1:0] o_removed;
    logic             o_ok;
    logic             o_empty;

    assign o_ok      = m_tdata[0];
    assign o_removed = m_tdata[REM_LO +: CNT_W];
    assign o_count   = m_tdata[CNT_LO +: CNT_W];
    assign o_empty   = m_tdata[EMPTY_B];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (o_empty == (o_count == '0)))
        else $error("empty flag disagrees with item count");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (o_count <= CNT_W'(CAPACITY)))
        else $error("item count beyond capacity");

    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (o_removed != '0) |-> o_ok)
        else $error("items removed without ok");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

endmodule

bind ordered_array_list_engine oale_checker #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH)
) u_oale_checker (.*);
